// ----- hdl/hopr_pkg.sv -----
// shared types, widths and constants of the helix offset rotation unit
package hopr_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 30;

  localparam int XY_W   = 34;  // cordic x/y, q1.30 with headroom
  localparam int Z_W    = 33;  // cordic residual angle, 2^-32 turn
  localparam int TRIG_W = 18;  // rounded sin/cos, q.16
  localparam int A_W    = 34;  // (t.n) t, 2^-28
  localparam int D_W    = 35;  // (t x n) x t, 2^-28
  localparam int C_W    = 33;  // t x n, 2^-28

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] RADIUS_RESET   = 32'h0001_0000;
  localparam logic [15:0] WINDINGS_RESET = 16'h0100;

  typedef logic signed [31:0]     coord_t;
  typedef logic signed [A_W-1:0]  avec_t;
  typedef logic signed [D_W-1:0]  dvec_t;
  typedef logic signed [C_W-1:0]  cvec_t;

  // per item values that ride along the cell chains
  typedef struct packed {
    coord_t [2:0] p;
    avec_t  [2:0] a;
    dvec_t  [2:0] d;
    cvec_t  [2:0] c;
  } side_t;

  // stage control handed from cell to cell
  typedef struct packed {
    logic en;
    logic valid;
  } ctl_t;

  // arctangent of 2^-step in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input int unsigned step);
    logic [29:0] r;
    case (step)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10680862;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41721;
      15: r = 30'd20860;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2607;
      19: r = 30'd1303;
      20: r = 30'd651;
      21: r = 30'd325;
      22: r = 30'd162;
      23: r = 30'd81;
      24: r = 30'd40;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd2;
      29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/hopr_prep.sv -----
// front stages: vector products, turn numerator and divisor
module hopr_prep
  import hopr_pkg::*;
#(
  parameter int AB = ANGLE_BITS_DEF,
  parameter int NW = AB + 24
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  coord_t [2:0]      point,
  input  logic [2:0][15:0]  tangent,
  input  logic [2:0][15:0]  normal,
  input  logic [15:0]       point_position,
  input  logic [15:0]       line_points,
  input  logic [15:0]       windings,
  output logic              valid,
  output logic [NW-1:0]     num,
  output logic [15:0]       den,
  output logic              zero,
  output side_t             side
);

  logic [2:0] v;
  coord_t p1 [3];
  coord_t p2 [3];
  coord_t p3 [3];
  coord_t p4 [3];
  logic signed [15:0] t1 [3];
  logic signed [15:0] t2 [3];
  logic signed [31:0] dm1 [3];
  logic signed [31:0] pm1 [3];
  logic signed [31:0] qm1 [3];
  logic signed [C_W-1:0] tn2;
  cvec_t c2 [3];
  cvec_t c3 [3];
  cvec_t c4 [3];
  logic signed [49:0] at3 [3];
  logic signed [49:0] ca3 [3];
  logic signed [49:0] cb3 [3];
  avec_t a4 [3];
  dvec_t d4 [3];
  logic [31:0] pw1, pw2, pw3, pw4;
  logic [15:0] cnt1, den2, den3;
  logic zero2, zero3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      v     <= {v[1:0], ctl.valid};
      valid <= v[2];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        p1[k]  <= point[k];
        p2[k]  <= p1[k];
        p3[k]  <= p2[k];
        p4[k]  <= p3[k];
        t1[k]  <= $signed(tangent[k]);
        t2[k]  <= t1[k];
        dm1[k] <= $signed(tangent[k]) * $signed(normal[k]);
        pm1[k] <= $signed(tangent[K1]) * $signed(normal[K2]);
        qm1[k] <= $signed(tangent[K2]) * $signed(normal[K1]);
        c2[k]  <= C_W'(pm1[k]) - C_W'(qm1[k]);
        c3[k]  <= c2[k];
        c4[k]  <= c3[k];
        at3[k] <= tn2 * t2[k];
        ca3[k] <= c2[K1] * t2[K2];
        cb3[k] <= c2[K2] * t2[K1];
        a4[k]  <= A_W'((at3[k] + 50'sd8192) >>> 14);
        d4[k]  <= D_W'((51'(ca3[k]) - 51'(cb3[k]) + 51'sd8192) >>> 14);
      end
    end
    assign side.p[k] = p4[k];
    assign side.a[k] = a4[k];
    assign side.d[k] = d4[k];
    assign side.c[k] = c4[k];
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pw1   <= point_position * windings;
      cnt1  <= line_points;
      tn2   <= C_W'(dm1[0]) + C_W'(dm1[1]) + C_W'(dm1[2]);
      pw2   <= pw1;
      den2  <= cnt1 - 16'd1;
      zero2 <= (cnt1 < 16'd2);
      pw3   <= pw2;
      den3  <= den2;
      zero3 <= zero2;
      pw4   <= pw3;
      den   <= den3;
      zero  <= zero3;
    end
  end

  assign num = {pw4, {(AB - 8){1'b0}}};

endmodule

// ----- hdl/hopr_div_cell.sv -----
// one restoring division cell: one numerator bit, one quotient bit
module hopr_div_cell
  import hopr_pkg::*;
#(
  parameter int AB = ANGLE_BITS_DEF,
  parameter int NW = AB + 24
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  input  logic [15:0]   rem_in,
  input  logic [15:0]   den_in,
  input  logic [NW-1:0] num_in,
  input  logic [AB-1:0] quo_in,
  input  logic          zero_in,
  input  side_t         side_in,
  output logic          valid,
  output logic [15:0]   rem,
  output logic [15:0]   den,
  output logic [NW-1:0] num,
  output logic [AB-1:0] quo,
  output logic          zero,
  output side_t         side
);

  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_in, num_in[NW-1]};
  assign fits  = (trial >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
    if (ctl.en) begin
      rem  <= fits ? 16'(trial - {1'b0, den_in}) : trial[15:0];
      den  <= den_in;
      num  <= {num_in[NW-2:0], 1'b0};
      quo  <= {quo_in[AB-2:0], fits};
      zero <= zero_in;
      side <= side_in;
    end
  end

`ifndef SYNTHESIS
  // partial remainder always stays below a nonzero divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (valid && !zero) |-> (rem < den))
    else $error("division remainder not below divisor");
`endif

endmodule

// ----- hdl/hopr_cordic_cell.sv -----
// one cordic rotation cell with a fixed shift and arctangent
module hopr_cordic_cell
  import hopr_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  input  logic [1:0]             quad_in,
  input  side_t                  side_in,
  output logic                   valid,
  output logic signed [XY_W-1:0] x,
  output logic signed [XY_W-1:0] y,
  output logic signed [Z_W-1:0]  z,
  output logic [1:0]             quad,
  output side_t                  side
);

  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  ang;

  assign dx  = x_in >>> STEP;
  assign dy  = y_in >>> STEP;
  assign ang = $signed(Z_W'(atan_turn(STEP)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
    if (ctl.en) begin
      if (!z_in[Z_W-1]) begin
        x <= x_in - dy;
        y <= y_in + dx;
        z <= z_in - ang;
      end else begin
        x <= x_in + dy;
        y <= y_in - dx;
        z <= z_in + ang;
      end
      quad <= quad_in;
      side <= side_in;
    end
  end

`ifndef SYNTHESIS
  // residual angle never leaves a quarter turn
  a_z_bounded: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((z <= 33'sd1073741824) && (z >= -33'sd1073741824)))
    else $error("cordic residual angle out of range");
`endif

endmodule

// ----- hdl/hopr_post.sv -----
// back stages: quadrant fold, rodrigues sum, radius scale, point add
module hopr_post
  import hopr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic [1:0]             quad_in,
  input  side_t                  side_in,
  input  logic [31:0]            radius,
  output logic                   valid,
  output coord_t [2:0]           helix
);

  logic [3:0] v;
  logic signed [XY_W-1:0] cs_raw, sn_raw;
  logic signed [TRIG_W-1:0] cs0, sn0;
  side_t side0;
  coord_t p1 [3];
  coord_t p2 [3];
  coord_t p3 [3];
  avec_t a1 [3];
  logic signed [52:0] m1 [3];
  logic signed [52:0] m2 [3];
  logic signed [31:0] u2 [3];
  logic signed [64:0] pr3 [3];

  always_comb begin
    case (quad_in)
      2'd0: begin
        cs_raw = x_in;
        sn_raw = y_in;
      end
      2'd1: begin
        cs_raw = -y_in;
        sn_raw = x_in;
      end
      2'd2: begin
        cs_raw = -x_in;
        sn_raw = -y_in;
      end
      default: begin
        cs_raw = y_in;
        sn_raw = -x_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (ctl.en) begin
      v     <= {v[2:0], ctl.valid};
      valid <= v[3];
    end
    if (ctl.en) begin
      cs0   <= TRIG_W'((cs_raw + 34'sd8192) >>> 14);
      sn0   <= TRIG_W'((sn_raw + 34'sd8192) >>> 14);
      side0 <= side_in;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [55:0] acc;
    logic signed [55:0] ur;
    logic signed [37:0] off;
    logic signed [37:0] sum;

    always_comb begin
      acc = (56'($signed(a1[k])) <<< 16) + 56'(m1[k]) + 56'(m2[k]);
      ur  = (acc + 56'sd32768) >>> 16;
      off = 38'((pr3[k] + 65'sd134217728) >>> 28);
      sum = 38'(p3[k]) + off;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        p1[k] <= $signed(side0.p[k]);
        p2[k] <= p1[k];
        p3[k] <= p2[k];
        a1[k] <= $signed(side0.a[k]);
        m1[k] <= cs0 * $signed(side0.d[k]);
        m2[k] <= sn0 * $signed(side0.c[k]);
        // unit vector clamps just inside +-8.0
        if (ur > 56'sd2147483647) begin
          u2[k] <= 32'sh7FFF_FFFF;
        end else if (ur < -56'sd2147483647) begin
          u2[k] <= -32'sh7FFF_FFFF;
        end else begin
          u2[k] <= ur[31:0];
        end
        pr3[k] <= $signed({1'b0, radius}) * u2[k];
        if (sum > 38'sd2147483647) begin
          helix[k] <= 32'sh7FFF_FFFF;
        end else if (sum < -38'sd2147483648) begin
          helix[k] <= 32'sh8000_0000;
        end else begin
          helix[k] <= sum[31:0];
        end
      end
    end
  end

endmodule

// ----- hdl/helix_offset_point_rotation_unit.sv -----
// helix offset point rotation unit: top level with register port and cell chains
// pipeline: 4 front stages, ANGLE_BITS + 24 divide cells, 30 cordic cells,
//   5 back stages including the output register
// throughput: one item per cycle; the whole pipeline holds while a result waits
//   at the output and the receiver is not ready
// reset: synchronous; clears all stage valid bits, radius to 1.0, windings to 1.0
module helix_offset_point_rotation_unit
  import hopr_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, tangent_x, tangent_y, tangent_z,
  // normal_x, normal_y, normal_z, point_position, line_points
  input  logic [223:0] s_axis_tdata,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // helix_x, helix_y, helix_z
  output logic [95:0]  m_axis_tdata
);

  localparam int NW = ANGLE_BITS + 24;  // numerator bits: 24 integer, ANGLE_BITS fraction

  typedef enum logic {
    REG_RADIUS,
    REG_WINDINGS
  } reg_idx_t;

  reg_idx_t    reg_idx;
  logic [31:0] radius;
  logic [15:0] windings;
  logic        en;

  // register file, one word per register
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RESET;
      windings <= WINDINGS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_RADIUS:   radius   <= pwdata;
        REG_WINDINGS: windings <= pwdata[15:0];
        default:      radius   <= radius;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS:   prdata = radius;
      REG_WINDINGS: prdata = {16'd0, windings};
      default:      prdata = '0;
    endcase
  end

  // global advance: move when the output slot is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the input item
  coord_t [2:0]     in_point;
  logic [2:0][15:0] in_tangent;
  logic [2:0][15:0] in_normal;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign in_point[k]   = s_axis_tdata[32*k +: 32];
    assign in_tangent[k] = s_axis_tdata[96 + 16*k +: 16];
    assign in_normal[k]  = s_axis_tdata[144 + 16*k +: 16];
  end

  // front stages
  logic          pre_valid;
  logic [NW-1:0] pre_num;
  logic [15:0]   pre_den;
  logic          pre_zero;
  side_t         pre_side;

  hopr_prep #(.AB(ANGLE_BITS), .NW(NW)) u_prep (
    .clk            (clk),
    .rst            (rst),
    .ctl            ('{en: en, valid: s_axis_tvalid}),
    .point          (in_point),
    .tangent        (in_tangent),
    .normal         (in_normal),
    .point_position (s_axis_tdata[207:192]),
    .line_points    (s_axis_tdata[223:208]),
    .windings       (windings),
    .valid          (pre_valid),
    .num            (pre_num),
    .den            (pre_den),
    .zero           (pre_zero),
    .side           (pre_side)
  );

  // divide chain: phase = numerator / divisor, low ANGLE_BITS quotient bits kept
  logic                  dv   [NW+1];
  logic [15:0]           drem [NW+1];
  logic [15:0]           dden [NW+1];
  logic [NW-1:0]         dnum [NW+1];
  logic [ANGLE_BITS-1:0] dquo [NW+1];
  logic                  dzr  [NW+1];
  side_t                 dsd  [NW+1];

  assign dv[0]   = pre_valid;
  assign drem[0] = '0;
  assign dden[0] = pre_den;
  assign dnum[0] = pre_num;
  assign dquo[0] = '0;
  assign dzr[0]  = pre_zero;
  assign dsd[0]  = pre_side;

  for (genvar i = 0; i < NW; i++) begin : g_div
    hopr_div_cell #(.AB(ANGLE_BITS), .NW(NW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     ('{en: en, valid: dv[i]}),
      .rem_in  (drem[i]),
      .den_in  (dden[i]),
      .num_in  (dnum[i]),
      .quo_in  (dquo[i]),
      .zero_in (dzr[i]),
      .side_in (dsd[i]),
      .valid   (dv[i+1]),
      .rem     (drem[i+1]),
      .den     (dden[i+1]),
      .num     (dnum[i+1]),
      .quo     (dquo[i+1]),
      .zero    (dzr[i+1]),
      .side    (dsd[i+1])
    );
  end

  // a line of fewer than two points turns by zero
  logic [ANGLE_BITS-1:0] phase;
  assign phase = dzr[NW] ? '0 : dquo[NW];

  // cordic chain: quadrant from the top two phase bits, rest as a 2^-32 turn
  logic                   cv [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
  logic [1:0]             cq [CORDIC_STEPS+1];
  side_t                  cs [CORDIC_STEPS+1];

  assign cv[0] = dv[NW];
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = $signed({3'b000, phase[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
  assign cq[0] = phase[ANGLE_BITS-1:ANGLE_BITS-2];
  assign cs[0] = dsd[NW];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    hopr_cordic_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     ('{en: en, valid: cv[i]}),
      .x_in    (cx[i]),
      .y_in    (cy[i]),
      .z_in    (cz[i]),
      .quad_in (cq[i]),
      .side_in (cs[i]),
      .valid   (cv[i+1]),
      .x       (cx[i+1]),
      .y       (cy[i+1]),
      .z       (cz[i+1]),
      .quad    (cq[i+1]),
      .side    (cs[i+1])
    );
  end

  // back stages, last one is the output register
  coord_t [2:0] helix;

  hopr_post u_post (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, valid: cv[CORDIC_STEPS]}),
    .x_in    (cx[CORDIC_STEPS]),
    .y_in    (cy[CORDIC_STEPS]),
    .quad_in (cq[CORDIC_STEPS]),
    .side_in (cs[CORDIC_STEPS]),
    .radius  (radius),
    .valid   (m_axis_tvalid),
    .helix   (helix)
  );

  assign m_axis_tdata = {helix[2], helix[1], helix[0]};

`ifndef SYNTHESIS
  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a held result freezes the whole chain, input included
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result is held");

  // a held result keeps its value through the stall
  a_hold_frozen: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("held result changed");
`endif

endmodule
